### sv/gda_pkg.sv
// shared types, constants and calendar helpers for the date adder
package gda_pkg;

  // calendar limits
  localparam int MAX_YEAR = 9999;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int ADD_W    = 20;
  localparam int ACC_W    = ADD_W + 1;
  localparam int YLEN_W   = 9;
  localparam int CNT_RAW  = $clog2(MAX_YEAR + 2);
  localparam int CNT_W    = (CNT_RAW > YEAR_W) ? CNT_RAW : YEAR_W;
  localparam int REM_W    = 9;

  localparam logic [REM_W-1:0] QUAD_CENT = REM_W'(400);
  localparam logic [YEAR_W-1:0] QUAD_CENT_Y = YEAR_W'(400);
  localparam logic [MONTH_W-1:0] DEC = MONTH_W'(12);

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ILLEGAL = 2'd1,
    STAT_OVER    = 2'd2
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    red_step;
    logic    acc_step;
    logic    year_step;
    logic    mwalk_init;
    logic    mwalk_step;
    logic    finish;
    status_e fin_code;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic field_bad;
    logic red_done;
    logic day_bad;
    logic mon_done;
    logic year_done;
    logic year_over;
    logic mwalk_done;
    logic out_free;
  } stat_t;

  // days in a month, leap flag selects february length
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
      4'd2:                    len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                 len = DAY_W'(31);
    endcase
    return len;
  endfunction

  // days in a year
  function automatic logic [YLEN_W-1:0] year_len(input logic leap);
    return leap ? YLEN_W'(366) : YLEN_W'(365);
  endfunction

  // year mod 100 from year mod 400
  function automatic logic [REM_W-1:0] mod_cent(input logic [REM_W-1:0] r);
    logic [REM_W-1:0] res;
    if (r < REM_W'(100)) begin
      res = r;
    end else if (r < REM_W'(200)) begin
      res = r - REM_W'(100);
    end else if (r < REM_W'(300)) begin
      res = r - REM_W'(200);
    end else begin
      res = r - REM_W'(300);
    end
    return res;
  endfunction

endpackage

### sv/gregorian_date_add_days_top.sv
// top level: date plus days, one request at a time, registered result
// sequence: load, reduce the year mod 400, add the start month lengths, walk the years,
//   walk the months, then finish; an illegal field ends the request before the reduction,
//   an out-of-range day after it
// one request at a time; the next one may start while a result waits
// reset: asynchronous active low, clears the controller and the result valid
module gregorian_date_add_days_top import gda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // start_year[13:0], start_month[17:14], start_day[22:18], days_to_add[42:23]
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_year[13:0], result_month[17:14], result_day[22:18]
  output logic [23:0] m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]  m_axis_tuser_o
);

  cmd_t               cmd;
  stat_t              stat;
  logic [YEAR_W-1:0]  result_year;
  logic [MONTH_W-1:0] result_month;
  logic [DAY_W-1:0]   result_day;
  status_e            status;

  // sequencing
  gda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic and result register
  gda_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .start_year_i   (s_axis_tdata_i[13:0]),
    .start_month_i  (s_axis_tdata_i[17:14]),
    .start_day_i    (s_axis_tdata_i[22:18]),
    .days_to_add_i  (s_axis_tdata_i[42:23]),
    .res_valid_o    (m_axis_tvalid_o),
    .res_ready_i    (m_axis_tready_i),
    .result_year_o  (result_year),
    .result_month_o (result_month),
    .result_day_o   (result_day),
    .status_o       (status)
  );

  // pack the result
  assign m_axis_tdata_o = {1'b0, result_day, result_month, result_year};
  assign m_axis_tuser_o = status;

endmodule

### sv/gda_datapath.sv
// datapath: operand registers, year and month walkers, result register
module gda_datapath import gda_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic [YEAR_W-1:0]  start_year_i,
  input  logic [MONTH_W-1:0] start_month_i,
  input  logic [DAY_W-1:0]   start_day_i,
  input  logic [ADD_W-1:0]   days_to_add_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [YEAR_W-1:0]  result_year_o,
  output logic [MONTH_W-1:0] result_month_o,
  output logic [DAY_W-1:0]   result_day_o,
  output status_e            status_o
);

  logic [CNT_W-1:0]   year_q, year_d;
  logic [YEAR_W-1:0]  rem_q, rem_d;
  logic [MONTH_W-1:0] month_q, month_d;
  logic [DAY_W-1:0]   day_q, day_d;
  logic [MONTH_W-1:0] mcnt_q, mcnt_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               out_valid_q;
  logic [YEAR_W-1:0]  res_year_q;
  logic [MONTH_W-1:0] res_month_q;
  logic [DAY_W-1:0]   res_day_q;
  status_e            res_status_q;

  logic [REM_W-1:0]   rem_low;
  logic               leap;
  logic [DAY_W-1:0]   cur_mlen;
  logic [YLEN_W-1:0]  cur_ylen;

  // leap rule from the running year remainders
  assign rem_low  = rem_q[REM_W-1:0];
  assign leap     = ((year_q[1:0] == 2'd0) && (mod_cent(rem_low) != '0)) ||
                    (rem_low == '0);
  assign cur_mlen = month_len(mcnt_q, leap);
  assign cur_ylen = year_len(leap);

  // status toward the controller
  always_comb begin
    stat_o.field_bad  = (year_q == '0) || (year_q > CNT_W'(MAX_YEAR)) ||
                        (month_q == '0) || (month_q > DEC) || (day_q == '0);
    stat_o.red_done   = (rem_q < QUAD_CENT_Y);
    stat_o.day_bad    = (day_q > month_len(month_q, leap));
    stat_o.mon_done   = (mcnt_q == month_q);
    stat_o.year_over  = (year_q > CNT_W'(MAX_YEAR));
    stat_o.year_done  = (acc_q <= ACC_W'(cur_ylen));
    stat_o.mwalk_done = (mcnt_q == DEC) || (acc_q <= ACC_W'(cur_mlen));
    stat_o.out_free   = !out_valid_q || res_ready_i;
  end

  // next values of the working registers
  always_comb begin
    year_d  = year_q;
    rem_d   = rem_q;
    month_d = month_q;
    day_d   = day_q;
    mcnt_d  = mcnt_q;
    acc_d   = acc_q;
    if (cmd_i.load) begin
      year_d  = CNT_W'(start_year_i);
      rem_d   = start_year_i;
      month_d = start_month_i;
      day_d   = start_day_i;
      mcnt_d  = MONTH_W'(1);
      acc_d   = ACC_W'(start_day_i) + ACC_W'(days_to_add_i);
    end
    if (cmd_i.red_step) begin
      rem_d = rem_q - QUAD_CENT_Y;
    end
    if (cmd_i.acc_step) begin
      acc_d  = acc_q + ACC_W'(cur_mlen);
      mcnt_d = mcnt_q + MONTH_W'(1);
    end
    if (cmd_i.year_step) begin
      acc_d  = acc_q - ACC_W'(cur_ylen);
      year_d = year_q + CNT_W'(1);
      rem_d  = (rem_low == QUAD_CENT - REM_W'(1)) ? '0 : rem_q + YEAR_W'(1);
    end
    if (cmd_i.mwalk_init) begin
      mcnt_d = MONTH_W'(1);
    end
    if (cmd_i.mwalk_step) begin
      acc_d  = acc_q - ACC_W'(cur_mlen);
      mcnt_d = mcnt_q + MONTH_W'(1);
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    year_q  <= year_d;
    rem_q   <= rem_d;
    month_q <= month_d;
    day_q   <= day_d;
    mcnt_q  <= mcnt_d;
    acc_q   <= acc_d;
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, zero unless ok
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_status_q <= cmd_i.fin_code;
      if (cmd_i.fin_code == STAT_OK) begin
        res_year_q  <= year_q[YEAR_W-1:0];
        res_month_q <= mcnt_q;
        res_day_q   <= acc_q[DAY_W-1:0];
      end else begin
        res_year_q  <= '0;
        res_month_q <= '0;
        res_day_q   <= '0;
      end
    end
  end

  assign res_valid_o    = out_valid_q;
  assign result_year_o  = res_year_q;
  assign result_month_o = res_month_q;
  assign result_day_o   = res_day_q;
  assign status_o       = res_status_q;

`ifndef ASSERT_OFF
  // an ok result carries a real month and day
  a_ok_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_status_q == STAT_OK) |->
      (res_month_q != '0) && (res_month_q <= DEC) && (res_day_q != '0))
    else $error("ok result with empty month or day");

  // a failed result is all zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_status_q != STAT_OK) |->
      (res_year_q == '0) && (res_month_q == '0) && (res_day_q == '0))
    else $error("failed result with nonzero date");

  // year walk runs on a reduced remainder
  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.year_step |-> (rem_q < QUAD_CENT_Y))
    else $error("year step with unreduced remainder");

  // month walk stops at december
  a_mwalk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mwalk_step |-> (mcnt_q < DEC) && (acc_q != '0))
    else $error("month walk past december");
`endif

endmodule

### sv/gda_ctrl.sv
// controller: sequences check, reduction, accumulation and the two walks
module gda_ctrl import gda_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_REDUCE = 6'b000010,
    ST_ACCUM  = 6'b000100,
    ST_YEARS  = 6'b001000,
    ST_MONTHS = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e  state_q, state_d;
  status_e code_q, code_d;

  assign req_ready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d  = state_q;
    code_d   = code_q;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (stat_i.field_bad) begin
          code_d  = STAT_ILLEGAL;
          state_d = ST_DONE;
        end else if (!stat_i.red_done) begin
          cmd_o.red_step = 1'b1;
        end else if (stat_i.day_bad) begin
          code_d  = STAT_ILLEGAL;
          state_d = ST_DONE;
        end else begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (stat_i.mon_done) begin
          state_d = ST_YEARS;
        end else begin
          cmd_o.acc_step = 1'b1;
        end
      end
      ST_YEARS: begin
        if (stat_i.year_over) begin
          code_d  = STAT_OVER;
          state_d = ST_DONE;
        end else if (stat_i.year_done) begin
          cmd_o.mwalk_init = 1'b1;
          state_d          = ST_MONTHS;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      ST_MONTHS: begin
        if (stat_i.mwalk_done) begin
          code_d  = STAT_OK;
          state_d = ST_DONE;
        end else begin
          cmd_o.mwalk_step = 1'b1;
        end
      end
      ST_DONE: begin
        cmd_o.fin_code = code_q;
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      code_q  <= STAT_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

`ifndef ASSERT_OFF
  // a request is taken only when the block is idle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_REDUCE))
    else $error("load did not start reduction");

  // at most one datapath step per cycle
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.red_step, cmd_o.acc_step, cmd_o.year_step,
              cmd_o.mwalk_step, cmd_o.finish}))
    else $error("conflicting datapath commands");

  // finishing returns to idle
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> req_ready_o)
    else $error("not idle after finish");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the date plus days block: directed corner table, then random requests
module testbench;
  import gda_pkg::*;

  localparam int N_PER_PHASE = 19;
  localparam int HOLD_CYCLES = 800;
  // longest request walks about 2900 years plus start offset and month walks
  localparam int TAIL_CYCLES = 3100;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [ADD_W-1:0]   days;
  } date_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    status_e            status;
  } date_res_t;

  typedef struct packed {
    date_req_t rq;
    logic      known;
    date_res_t res;
  } corner_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  date_res_t   pending_dates[$];
  corner_row_t corner_rows[25];
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_reqs = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  gregorian_date_add_days_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, pending_dates.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // calendar rules
  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      4, 6, 9, 11: len = 30;
      2:           len = is_leap(y) ? 29 : 28;
      default:     len = 31;
    endcase
    return len;
  endfunction

  function automatic int unsigned days_in_year(input int unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  // expected date: validate, go to a one-based day number, add, walk back
  function automatic date_res_t date_after_days(input date_req_t rq);
    date_res_t   r;
    int unsigned y;
    int unsigned m;
    int unsigned prev;
    int unsigned serial;
    r = '0;
    r.status = STAT_OK;
    y = rq.year;
    m = rq.month;
    if (y == 0 || y > MAX_YEAR || m == 0 || m > 12 || rq.day == 0 ||
        rq.day > days_in_month(y, m)) begin
      r.status = STAT_ILLEGAL;
      return r;
    end
    prev = y - 1;
    serial = 365 * prev + prev / 4 - prev / 100 + prev / 400;
    for (int unsigned i = 1; i < m; i++) begin
      serial += days_in_month(y, i);
    end
    serial += rq.day + rq.days;
    y = 1;
    while (y <= MAX_YEAR && serial > days_in_year(y)) begin
      serial -= days_in_year(y);
      y++;
    end
    if (y > MAX_YEAR) begin
      r.status = STAT_OVER;
      return r;
    end
    m = 1;
    while (m < 12 && serial > days_in_month(y, m)) begin
      serial -= days_in_month(y, m);
      m++;
    end
    r.year  = YEAR_W'(y);
    r.month = MONTH_W'(m);
    r.day   = DAY_W'(serial);
    return r;
  endfunction

  function automatic corner_row_t mk_row(input int y, input int m, input int d, input int n,
                                         input bit known, input int ey, input int em,
                                         input int ed, input status_e st);
    corner_row_t row;
    row.rq    = '{YEAR_W'(y), MONTH_W'(m), DAY_W'(d), ADD_W'(n)};
    row.known = known;
    row.res   = '{YEAR_W'(ey), MONTH_W'(em), DAY_W'(ed), st};
    return row;
  endfunction

  // mostly legal dates with random content, some noise over the whole field range
  function automatic date_req_t random_request();
    date_req_t   rq;
    int unsigned y;
    int unsigned m;
    int unsigned len;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      rq.year  = YEAR_W'($urandom_range(0, 16383));
      rq.month = MONTH_W'($urandom_range(0, 15));
      rq.day   = DAY_W'($urandom_range(0, 31));
    end else begin
      case ($urandom_range(9))
        0: begin
          case ($urandom_range(5))
            0:       y = 1;
            1:       y = 400;
            2:       y = 1900;
            3:       y = 2000;
            4:       y = 2100;
            default: y = MAX_YEAR;
          endcase
        end
        1:       y = $urandom_range(8192, MAX_YEAR);
        default: y = $urandom_range(1, MAX_YEAR);
      endcase
      m = $urandom_range(1, 12);
      len = days_in_month(y, m);
      rq.year  = YEAR_W'(y);
      rq.month = MONTH_W'(m);
      rq.day   = DAY_W'(($urandom_range(3) == 0) ? len : $urandom_range(1, len));
    end
    pick = $urandom_range(99);
    if (pick < 60) begin
      rq.days = ADD_W'($urandom_range(0, 400));
    end else if (pick < 85) begin
      rq.days = ADD_W'($urandom_range(0, 20000));
    end else begin
      rq.days = ADD_W'($urandom_range(0, 20'hFFFFF));
    end
    return rq;
  endfunction

  // offer one request, called at a falling edge, returns at a falling edge
  task automatic offer_request(input date_req_t rq, input date_res_t want);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'd0, rq.days, rq.day, rq.month, rq.year};
    forever begin
      @(posedge clk_i);
      if (s_axis_tvalid_i && s_axis_tready_o) break;
    end
    pending_dates.push_back(want);
    @(negedge clk_i);
  endtask

  // stop offering and wait until every pending result is back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (pending_dates.size() == 0) break;
    end
  endtask

  // receiver ready, with random stalls and requested long hold-offs
  always @(negedge clk_i) begin
    if (hold_left == 0 && hold_reqs != hold_served) begin
      hold_served = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result check against the oldest pending date
  always @(posedge clk_i) begin
    date_res_t got;
    date_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{m_axis_tdata_o[13:0], m_axis_tdata_o[17:14], m_axis_tdata_o[22:18],
              status_e'(m_axis_tuser_o)};
      if (pending_dates.size() == 0) begin
        $display("%0t: result with nothing pending, actual %0d-%0d-%0d status %0d",
                 $time, got.year, got.month, got.day, got.status);
        err_cnt++;
      end else begin
        want = pending_dates.pop_front();
        if (got.year !== want.year) begin
          $display("%0t: year mismatch, expected %0d actual %0d", $time, want.year, got.year);
          err_cnt++;
        end
        if (got.month !== want.month) begin
          $display("%0t: month mismatch, expected %0d actual %0d", $time, want.month,
                   got.month);
          err_cnt++;
        end
        if (got.day !== want.day) begin
          $display("%0t: day mismatch, expected %0d actual %0d", $time, want.day, got.day);
          err_cnt++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status,
                   got.status);
          err_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    date_req_t rq;
    date_res_t want;
    corner_rows[0]  = mk_row(1, 1, 1, 0, 1, 1, 1, 1, STAT_OK);
    corner_rows[1]  = mk_row(9999, 12, 31, 0, 1, 9999, 12, 31, STAT_OK);
    corner_rows[2]  = mk_row(9999, 12, 31, 1, 1, 0, 0, 0, STAT_OVER);
    corner_rows[3]  = mk_row(9999, 1, 1, 364, 1, 9999, 12, 31, STAT_OK);
    corner_rows[4]  = mk_row(9999, 1, 1, 365, 1, 0, 0, 0, STAT_OVER);
    corner_rows[5]  = mk_row(0, 1, 1, 0, 1, 0, 0, 0, STAT_ILLEGAL);
    corner_rows[6]  = mk_row(10000, 6, 15, 10, 1, 0, 0, 0, STAT_ILLEGAL);
    corner_rows[7]  = mk_row(16383, 15, 31, 20'hFFFFF, 1, 0, 0, 0, STAT_ILLEGAL);
    corner_rows[8]  = mk_row(2000, 0, 1, 5, 1, 0, 0, 0, STAT_ILLEGAL);
    corner_rows[9]  = mk_row(2000, 13, 1, 5, 1, 0, 0, 0, STAT_ILLEGAL);
    corner_rows[10] = mk_row(2000, 15, 1, 5, 1, 0, 0, 0, STAT_ILLEGAL);
    corner_rows[11] = mk_row(2000, 1, 0, 5, 1, 0, 0, 0, STAT_ILLEGAL);
    corner_rows[12] = mk_row(2000, 2, 29, 0, 1, 2000, 2, 29, STAT_OK);
    corner_rows[13] = mk_row(1900, 2, 29, 0, 1, 0, 0, 0, STAT_ILLEGAL);
    corner_rows[14] = mk_row(2100, 2, 29, 0, 1, 0, 0, 0, STAT_ILLEGAL);
    corner_rows[15] = mk_row(2023, 2, 29, 0, 1, 0, 0, 0, STAT_ILLEGAL);
    corner_rows[16] = mk_row(2023, 4, 31, 0, 1, 0, 0, 0, STAT_ILLEGAL);
    corner_rows[17] = mk_row(2024, 2, 29, 1, 1, 2024, 3, 1, STAT_OK);
    corner_rows[18] = mk_row(2023, 12, 31, 1, 1, 2024, 1, 1, STAT_OK);
    corner_rows[19] = mk_row(1, 1, 1, 20'hFFFFF, 0, 0, 0, 0, STAT_OK);
    corner_rows[20] = mk_row(9000, 6, 15, 20'hFFFFF, 0, 0, 0, 0, STAT_OK);
    corner_rows[21] = mk_row(8192, 8, 16, 20'h80000, 0, 0, 0, 0, STAT_OK);
    corner_rows[22] = mk_row(1999, 11, 30, 31, 1, 1999, 12, 31, STAT_OK);
    corner_rows[23] = mk_row(2000, 1, 31, 29, 0, 0, 0, 0, STAT_OK);
    corner_rows[24] = mk_row(1, 1, 1, 365, 1, 2, 1, 1, STAT_OK);

    // reset
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corners, no idling
    foreach (corner_rows[i]) begin
      rq = corner_rows[i].rq;
      want = corner_rows[i].known ? corner_rows[i].res : date_after_days(rq);
      offer_request(rq, want);
    end

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 45;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 45;
        end
        default: begin
          idle_pct = 26;
          stall_pct = 26;
        end
      endcase
      for (int k = 0; k < N_PER_PHASE; k++) begin
        // long receiver hold-off while requests keep coming
        if (ph == 2 && k == 5) hold_reqs++;
        rq = random_request();
        offer_request(rq, date_after_days(rq));
      end
    end

    // wind down
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
sv/gda_pkg.sv
sv/gda_datapath.sv
sv/gda_ctrl.sv
sv/gregorian_date_add_days_top.sv
tb/testbench.sv
